// ----- hdl/sft_pkg.sv -----
`default_nettype none
package sft_pkg;

  localparam int COORD_W   = 20;
  localparam int MAX_PAIRS = 128;
  localparam int ADDR_W    = $clog2(MAX_PAIRS);
  localparam int CNT_W     = 8;
  localparam int SUM_W     = 28;
  localparam int LANE_W    = 2 * COORD_W + 1;
  localparam int ACC_W     = 48;
  localparam int WACC_W    = 62;
  localparam int MAG_W     = 60;
  localparam int DVS_W     = 59;
  localparam int REM_W     = 60;
  localparam int QB_W      = 45;
  localparam int STEP_W    = 6;
  localparam int COEF_W    = 32;
  localparam int SHIFT_W   = 28;
  localparam int FRAC_BITS = 16;
  localparam int RATIO_STEPS = 32;
  localparam int SAT_SHIFT = 15;
  localparam int SAT_W     = DVS_W + FRAC_BITS;
  localparam int ONE_Q16   = 65536;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DEGEN = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] src_x;
    logic signed [COORD_W-1:0] src_y;
    logic signed [COORD_W-1:0] dst_x;
    logic signed [COORD_W-1:0] dst_y;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]  scale_cos;
    logic signed [COEF_W-1:0]  scale_sin;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
    logic [1:0]                status;
    logic [CNT_W-1:0]          pair_count;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
  } pair_t;

  localparam int PAIR_W = $bits(pair_t);

  typedef struct packed {
    logic [CNT_W-1:0]        n;
    logic signed [SUM_W-1:0] ssx;
    logic signed [SUM_W-1:0] ssy;
    logic signed [SUM_W-1:0] sdx;
    logic signed [SUM_W-1:0] sdy;
    logic                    ovf;
  } launch_t;

endpackage
`default_nettype wire

// ----- hdl/sft_ram.sv -----
`default_nettype none
module sft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/sft_div.sv -----
`default_nettype none
module sft_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [sft_pkg::REM_W-1:0]  r0,
  input  wire logic [sft_pkg::QB_W-1:0]   bits,
  input  wire logic [sft_pkg::STEP_W-1:0] steps,
  input  wire logic [sft_pkg::DVS_W-1:0]  dvs,
  output logic                            done,
  output logic [sft_pkg::QB_W-1:0]        quo,
  output logic                            rnd
);
  import sft_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic [REM_W-1:0]  rem_r;
  logic [QB_W-1:0]   bits_r;
  logic [QB_W-1:0]   quo_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // Restoring division: one quotient bit per cycle, dividend bits shifted in MSB first.
  assign trial = {rem_r[REM_W-2:0], bits_r[QB_W-1]};
  assign ge    = trial >= REM_W'(dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= r0;
      bits_r <= bits;
      quo_r  <= '0;
      cnt_r  <= steps;
      dvs_r  <= dvs;
    end else if (busy_r) begin
      rem_r  <= ge ? trial - REM_W'(dvs_r) : trial;
      bits_r <= {bits_r[QB_W-2:0], 1'b0};
      quo_r  <= {quo_r[QB_W-2:0], ge};
      cnt_r  <= cnt_r - STEP_W'(1);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  // Round half away from zero: the remainder is at least half the divisor.
  assign rnd  = {rem_r, 1'b0} >= (REM_W + 1)'(dvs_r);

endmodule
`default_nettype wire

// ----- hdl/sft_fit.sv -----
`default_nettype none
module sft_fit (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       launch_valid,
  input  wire sft_pkg::launch_t           launch,
  output logic                            busy,
  output logic                            rd_en,
  output logic [sft_pkg::ADDR_W-1:0]      rd_addr,
  input  wire sft_pkg::pair_t             rd_data,
  output logic                            res_valid,
  output sft_pkg::out_item_t              res,
  input  wire logic                       res_take
);
  import sft_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_MULA   = 4'd2;
  localparam logic [3:0] S_CHK    = 4'd3;
  localparam logic [3:0] S_PREP   = 4'd4;
  localparam logic [3:0] S_DSTART = 4'd5;
  localparam logic [3:0] S_DWAIT  = 4'd6;
  localparam logic [3:0] S_DPOST  = 4'd7;
  localparam logic [3:0] S_MULB   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam logic [3:0] OP_A_NP  = 4'd0;
  localparam logic [3:0] OP_A_XX  = 4'd1;
  localparam logic [3:0] OP_A_YY  = 4'd2;
  localparam logic [3:0] OP_B_NP  = 4'd3;
  localparam logic [3:0] OP_B_XY  = 4'd4;
  localparam logic [3:0] OP_B_YX  = 4'd5;
  localparam logic [3:0] OP_D_NP  = 4'd6;
  localparam logic [3:0] OP_D_XX  = 4'd7;
  localparam logic [3:0] OP_D_YY  = 4'd8;
  localparam logic [3:0] OP_TX_0  = 4'd9;
  localparam logic [3:0] OP_TX_A  = 4'd10;
  localparam logic [3:0] OP_TX_B  = 4'd11;
  localparam logic [3:0] OP_TY_0  = 4'd12;
  localparam logic [3:0] OP_TY_B  = 4'd13;
  localparam logic [3:0] OP_TY_A  = 4'd14;
  localparam logic [3:0] OP_END   = 4'd15;

  localparam logic [1:0] DV_A  = 2'd0;
  localparam logic [1:0] DV_B  = 2'd1;
  localparam logic [1:0] DV_TX = 2'd2;
  localparam logic [1:0] DV_TY = 2'd3;

  localparam logic signed [COEF_W-1:0]  COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0]  COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = {1'b0, {(SHIFT_W-1){1'b1}}};
  localparam logic signed [SHIFT_W-1:0] SHIFT_MIN = {1'b1, {(SHIFT_W-1){1'b0}}};

  logic [3:0]               state_r;
  logic [CNT_W-1:0]         n_r;
  logic signed [SUM_W-1:0]  ssx_r, ssy_r, sdx_r, sdy_r;
  logic [1:0]               status_r;
  logic [CNT_W-1:0]         rd_idx_r;
  logic                     v1_r, v2_r;
  logic signed [LANE_W-1:0] ldot_r, lcross_r, lsq_r;
  logic signed [ACC_W-1:0]  pdot_r, pcross_r, psq_r;
  logic [3:0]               op_r;
  logic                     pend_v_r, pend_sub_r, pend_init_r;
  logic [1:0]               pend_dst_r;
  logic signed [WACC_W-1:0] prod_r;
  logic signed [WACC_W-1:0] acc_r [3];
  logic [1:0]               dv_r;
  logic [MAG_W-1:0]         mag_r;
  logic                     neg_r, sat_r;
  logic signed [COEF_W-1:0]  a_r, b_r;
  logic signed [SHIFT_W-1:0] tx_r, ty_r;

  // Per-entry products of the scan.
  logic signed [2*COORD_W-1:0] m_xx, m_yy, m_xy, m_yx, m_sxx, m_syy;
  assign m_xx  = rd_data.sx * rd_data.dx;
  assign m_yy  = rd_data.sy * rd_data.dy;
  assign m_xy  = rd_data.sx * rd_data.dy;
  assign m_yx  = rd_data.sy * rd_data.dx;
  assign m_sxx = rd_data.sx * rd_data.sx;
  assign m_syy = rd_data.sy * rd_data.sy;

  // Multiply micro-op decode.
  logic                     op_v, op_use_n, op_sub, op_init;
  logic [1:0]               op_dst;
  logic signed [ACC_W-1:0]  op_xn;
  logic signed [COEF_W-1:0] op_ma;
  logic signed [SUM_W-1:0]  op_mb;

  always_comb begin
    op_use_n = 1'b0;
    op_sub   = 1'b0;
    op_init  = 1'b0;
    op_dst   = 2'd0;
    op_xn    = pdot_r;
    op_ma    = COEF_W'(ssx_r);
    op_mb    = sdx_r;
    unique case (op_r)
      OP_A_NP: begin op_use_n = 1'b1; op_init = 1'b1; end
      OP_A_XX: begin op_sub = 1'b1; end
      OP_A_YY: begin op_sub = 1'b1; op_ma = COEF_W'(ssy_r); op_mb = sdy_r; end
      OP_B_NP: begin op_use_n = 1'b1; op_init = 1'b1; op_xn = pcross_r; op_dst = 2'd1; end
      OP_B_XY: begin op_sub = 1'b1; op_mb = sdy_r; op_dst = 2'd1; end
      OP_B_YX: begin op_ma = COEF_W'(ssy_r); op_dst = 2'd1; end
      OP_D_NP: begin op_use_n = 1'b1; op_init = 1'b1; op_xn = psq_r; op_dst = 2'd2; end
      OP_D_XX: begin op_sub = 1'b1; op_mb = ssx_r; op_dst = 2'd2; end
      OP_D_YY: begin
        op_sub = 1'b1; op_ma = COEF_W'(ssy_r); op_mb = ssy_r; op_dst = 2'd2;
      end
      OP_TX_0: begin op_init = 1'b1; op_ma = COEF_W'(ONE_Q16); end
      OP_TX_A: begin op_sub = 1'b1; op_ma = a_r; op_mb = ssx_r; end
      OP_TX_B: begin op_ma = b_r; op_mb = ssy_r; end
      OP_TY_0: begin op_init = 1'b1; op_ma = COEF_W'(ONE_Q16); op_mb = sdy_r; op_dst = 2'd1; end
      OP_TY_B: begin op_sub = 1'b1; op_ma = b_r; op_mb = ssx_r; op_dst = 2'd1; end
      OP_TY_A: begin op_sub = 1'b1; op_ma = a_r; op_mb = ssy_r; op_dst = 2'd1; end
      OP_END:  begin end
      default: begin end
    endcase
  end

  assign op_v = (state_r == S_MULA && op_r <= OP_D_YY) ||
                (state_r == S_MULB && op_r >= OP_TX_0 && op_r <= OP_TY_A);

  logic signed [CNT_W+ACC_W:0]   n_prod;
  logic signed [COEF_W+SUM_W-1:0] g_prod;
  assign n_prod = $signed({1'b0, n_r}) * op_xn;
  assign g_prod = op_ma * op_mb;

  logic signed [WACC_W-1:0] acc_base;
  assign acc_base = pend_init_r ? '0 : acc_r[pend_dst_r];

  // Division operands.
  logic                     is_ratio;
  logic signed [WACC_W-1:0] dsel;
  logic [DVS_W-1:0]         den;
  logic [REM_W-1:0]         d_r0;
  logic [QB_W-1:0]          d_bits;
  logic [STEP_W-1:0]        d_steps;
  logic [DVS_W-1:0]         d_dvs;
  logic                     d_done, d_rnd;
  logic [QB_W-1:0]          d_quo;
  logic [QB_W:0]            qr;
  logic signed [COEF_W-1:0]  coef_v, coef_res;
  logic signed [SHIFT_W-1:0] shift_v, shift_res;

  assign is_ratio = (dv_r == DV_A) || (dv_r == DV_B);
  assign dsel     = (dv_r == DV_A || dv_r == DV_TX) ? acc_r[0] : acc_r[1];
  assign den      = acc_r[2][DVS_W-1:0];

  always_comb begin
    if (is_ratio) begin
      d_r0    = REM_W'(mag_r >> FRAC_BITS);
      d_bits  = {mag_r[FRAC_BITS-1:0], {(QB_W-FRAC_BITS){1'b0}}};
      d_steps = STEP_W'(RATIO_STEPS);
      d_dvs   = den;
    end else begin
      d_r0    = REM_W'(mag_r >> QB_W);
      d_bits  = mag_r[QB_W-1:0];
      d_steps = STEP_W'(QB_W);
      d_dvs   = DVS_W'({n_r, {FRAC_BITS{1'b0}}});
    end
  end

  sft_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DSTART),
    .r0    (d_r0),
    .bits  (d_bits),
    .steps (d_steps),
    .dvs   (d_dvs),
    .done  (d_done),
    .quo   (d_quo),
    .rnd   (d_rnd)
  );

  assign qr = {1'b0, d_quo} + (QB_W + 1)'(d_rnd);

  always_comb begin
    coef_v = COEF_W'(qr);
    if (sat_r) begin
      coef_res = neg_r ? COEF_MIN : COEF_MAX;
    end else if (neg_r) begin
      coef_res = (qr >= ((QB_W + 1)'(1) << (COEF_W - 1))) ? COEF_MIN : -coef_v;
    end else begin
      coef_res = (qr >= (QB_W + 1)'(COEF_MAX)) ? COEF_MAX : coef_v;
    end
    shift_v = SHIFT_W'(qr);
    if (neg_r) begin
      shift_res = (qr >= ((QB_W + 1)'(1) << (SHIFT_W - 1))) ? SHIFT_MIN : -shift_v;
    end else begin
      shift_res = (qr >= (QB_W + 1)'(SHIFT_MAX)) ? SHIFT_MAX : shift_v;
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      pend_v_r <= op_v;
      v1_r     <= rd_en;
      v2_r     <= v1_r;
      unique case (state_r)
        S_IDLE: begin
          if (launch_valid) begin
            state_r <= launch.ovf ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_idx_r == n_r && !v1_r && !v2_r) begin
            state_r <= S_MULA;
          end
        end
        S_MULA:   if (op_r == OP_TX_0) state_r <= S_CHK;
        S_CHK:    state_r <= (acc_r[2] <= 0) ? S_DONE : S_PREP;
        S_PREP:   state_r <= S_DSTART;
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT:  if (d_done) state_r <= S_DPOST;
        S_DPOST: begin
          priority if (dv_r == DV_B) state_r <= S_MULB;
          else if (dv_r == DV_TY) state_r <= S_DONE;
          else state_r <= S_PREP;
        end
        S_MULB:   if (op_r == OP_END) state_r <= S_PREP;
        S_DONE:   if (res_take) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx_r <= rd_idx_r + CNT_W'(1);
    end
    if (v1_r) begin
      ldot_r   <= LANE_W'(m_xx) + LANE_W'(m_yy);
      lcross_r <= LANE_W'(m_xy) - LANE_W'(m_yx);
      lsq_r    <= LANE_W'(m_sxx) + LANE_W'(m_syy);
    end
    if (v2_r) begin
      pdot_r   <= pdot_r + ACC_W'(ldot_r);
      pcross_r <= pcross_r + ACC_W'(lcross_r);
      psq_r    <= psq_r + ACC_W'(lsq_r);
    end
    if (op_v) begin
      op_r        <= op_r + 4'd1;
      prod_r      <= op_use_n ? WACC_W'(n_prod) : WACC_W'(g_prod);
      pend_dst_r  <= op_dst;
      pend_sub_r  <= op_sub;
      pend_init_r <= op_init;
    end else if (state_r == S_MULA || state_r == S_MULB) begin
      op_r <= op_r + 4'd1;
    end
    if (pend_v_r) begin
      acc_r[pend_dst_r] <= pend_sub_r ? acc_base - prod_r : acc_base + prod_r;
    end
    unique case (state_r)
      S_IDLE: begin
        n_r      <= launch.n;
        ssx_r    <= launch.ssx;
        ssy_r    <= launch.ssy;
        sdx_r    <= launch.sdx;
        sdy_r    <= launch.sdy;
        status_r <= launch.ovf ? ST_OVF : ST_OK;
        rd_idx_r <= '0;
        pdot_r   <= '0;
        pcross_r <= '0;
        psq_r    <= '0;
        op_r     <= OP_A_NP;
        dv_r     <= DV_A;
        a_r      <= '0;
        b_r      <= '0;
        tx_r     <= '0;
        ty_r     <= '0;
      end
      S_CHK: begin
        if (acc_r[2] <= 0) begin
          status_r <= ST_DEGEN;
        end
      end
      S_PREP: begin
        neg_r <= dsel[WACC_W-1];
        mag_r <= MAG_W'(dsel[WACC_W-1] ? -dsel : dsel);
      end
      S_DSTART: begin
        // Integer part above 32768 saturates the coefficient outright.
        sat_r <= is_ratio &&
                 (SAT_W'(mag_r) >= (SAT_W'(den) << SAT_SHIFT) + SAT_W'(den));
      end
      S_DPOST: begin
        unique case (dv_r)
          DV_A:  a_r  <= coef_res;
          DV_B:  b_r  <= coef_res;
          DV_TX: tx_r <= shift_res;
          DV_TY: ty_r <= shift_res;
          default: begin end
        endcase
        dv_r <= dv_r + 2'd1;
        if (dv_r == DV_B) begin
          op_r <= OP_TX_0;
        end
      end
      default: begin end
    endcase
  end

  assign busy      = state_r != S_IDLE;
  assign rd_en     = (state_r == S_SCAN) && (rd_idx_r < n_r);
  assign rd_addr   = rd_idx_r[ADDR_W-1:0];
  assign res_valid = state_r == S_DONE;

  always_comb begin
    res.scale_cos  = a_r;
    res.scale_sin  = b_r;
    res.shift_x    = tx_r;
    res.shift_y    = ty_r;
    res.status     = status_r;
    res.pair_count = n_r;
  end

endmodule
`default_nettype wire

// ----- hdl/similarity_transform_fit.sv -----
`default_nettype none
// Least-squares 2-D similarity fit over a stream of point pairs.
// Input channel: one source/destination pair per item (in_valid, in_stall,
// in_item). Pairs are written to a 128-entry store, one item per cycle.
// The item flagged last closes the set: unless the set overran, the block
// scans the store (one entry per cycle), forms the centred sums with two
// shared multipliers and, for a non-degenerate set, runs four serial
// divisions for a, b and the two shifts. The serial divider takes 32 steps
// for each coefficient and 45 for each shift. in_stall stays high during
// the fit; other items are taken at one per cycle.
// Output channel: one result item per set (out_valid, out_stall, out_item).
// While the receiver stalls, the result waits in the output register and
// the fit unit holds its own finished result, so the store is free again
// only once the earlier result has been taken.
// Reset clears the pair count, overflow flag and running sums; the store
// itself needs no clearing, as only written entries are read.
module similarity_transform_fit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sft_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sft_pkg::out_item_t      out_item
);
  import sft_pkg::*;

  logic                    in_accept;
  logic                    room;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    ovf_r, ovf_nxt;
  logic signed [SUM_W-1:0] ssx_r, ssy_r, sdx_r, sdy_r;
  logic signed [SUM_W-1:0] ssx_nxt, ssy_nxt, sdx_nxt, sdy_nxt;
  launch_t                 launch;
  logic                    fit_busy;
  logic                    ram_re;
  logic [ADDR_W-1:0]       ram_raddr;
  pair_t                   ram_rdata;
  pair_t                   wpair;
  logic                    ram_we;
  logic                    res_valid, res_take;
  out_item_t               res;
  logic                    out_valid_r;
  out_item_t               out_item_r;

  assign in_stall  = fit_busy;
  assign in_accept = in_valid && !in_stall;
  assign room      = count_r < CNT_W'(MAX_PAIRS);
  assign ram_we    = in_accept && room;

  always_comb begin
    wpair.sx = in_item.src_x;
    wpair.sy = in_item.src_y;
    wpair.dx = in_item.dst_x;
    wpair.dy = in_item.dst_y;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    ssx_nxt   = ssx_r;
    ssy_nxt   = ssy_r;
    sdx_nxt   = sdx_r;
    sdy_nxt   = sdy_r;
    if (room) begin
      count_nxt = count_r + CNT_W'(1);
      ssx_nxt   = ssx_r + SUM_W'(in_item.src_x);
      ssy_nxt   = ssy_r + SUM_W'(in_item.src_y);
      sdx_nxt   = sdx_r + SUM_W'(in_item.dst_x);
      sdy_nxt   = sdy_r + SUM_W'(in_item.dst_y);
    end else begin
      ovf_nxt = 1'b1;
    end
    launch.n   = count_nxt;
    launch.ssx = ssx_nxt;
    launch.ssy = ssy_nxt;
    launch.sdx = sdx_nxt;
    launch.sdy = sdy_nxt;
    launch.ovf = ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      ssx_r   <= '0;
      ssy_r   <= '0;
      sdx_r   <= '0;
      sdy_r   <= '0;
    end else if (in_accept) begin
      if (in_item.last) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
        ssx_r   <= '0;
        ssy_r   <= '0;
        sdx_r   <= '0;
        sdy_r   <= '0;
      end else begin
        count_r <= count_nxt;
        ovf_r   <= ovf_nxt;
        ssx_r   <= ssx_nxt;
        ssy_r   <= ssy_nxt;
        sdx_r   <= sdx_nxt;
        sdy_r   <= sdy_nxt;
      end
    end
  end

  sft_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (MAX_PAIRS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (wpair),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sft_fit u_fit (
    .clk          (clk),
    .rst_n        (rst_n),
    .launch_valid (in_accept && in_item.last),
    .launch       (launch),
    .busy         (fit_busy),
    .rd_en        (ram_re),
    .rd_addr      (ram_raddr),
    .rd_data      (ram_rdata),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_PAIRS))
    else $error("pair count beyond store depth");

  a_fit_launch: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fit_busy) |-> $past(in_accept && in_item.last))
    else $error("fit started without a closing item");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> !ram_we)
    else $error("store written during scan");

  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_OVF) |->
      (out_item.scale_cos == 0 && out_item.shift_x == 0 &&
       out_item.pair_count == CNT_W'(MAX_PAIRS)))
    else $error("overflow result carries data");
`endif

endmodule
`default_nettype wire

// ----- tb/similarity_transform_fit_test.sv -----
`default_nettype none
module similarity_transform_fit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sft_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;

  similarity_transform_fit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: the pairs of the open set, its running sums and flags.
  longint set_sx[MAX_PAIRS];
  longint set_sy[MAX_PAIRS];
  longint set_dx[MAX_PAIRS];
  longint set_dy[MAX_PAIRS];
  int unsigned set_count = 0;
  bit set_overflow = 1'b0;
  longint sum_sx = 0, sum_sy = 0, sum_dx = 0, sum_dy = 0;

  out_item_t pending_fits[$];
  int in_idle_pct = 36;
  int out_idle_pct = 36;
  int mismatches = 0;
  int fits_seen = 0;
  int items_sent = 0;
  int overflow_sets = 0;
  int degenerate_sets = 0;
  longint cycles = 0;

  function automatic logic signed [COEF_W-1:0] q16_ratio(longint num, longint unsigned den);
    longint unsigned m, q, r;
    m = (num < 0) ? 64'd0 - longint'(num) : num;
    q = m / den;
    r = m % den;
    if (q > 64'd32768) begin
      q = 64'd1 << 32;
    end else begin
      for (int i = 0; i < FRAC_BITS; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 64'd1;
        end
      end
      if (r >= den - r) q = q + 1;
    end
    if (num < 0) return (q >= 64'h8000_0000) ? 32'sh8000_0000 : -q[31:0];
    return (q >= 64'h7fff_ffff) ? 32'sh7fff_ffff : q[31:0];
  endfunction

  function automatic logic signed [SHIFT_W-1:0] rounded_shift(longint num, longint unsigned den);
    longint unsigned m, q, r;
    m = (num < 0) ? 64'd0 - longint'(num) : num;
    q = m / den;
    r = m % den;
    if (r >= den - r) q = q + 1;
    if (num < 0) return (q >= 64'd134217728) ? 28'sh800_0000 : -q[27:0];
    return (q >= 64'd134217727) ? 28'sh7ff_ffff : q[27:0];
  endfunction

  // Advances the open set by one accepted item; a closing item queues a fit.
  task automatic fit_model(in_item_t it);
    longint unsigned n, dot_sum, cross_sum, spread_sum, ssx, ssy, sdx, sdy, ua, ub;
    longint num_a, num_b, den;
    out_item_t fit;
    if (set_count < MAX_PAIRS) begin
      set_sx[set_count] = it.src_x;
      set_sy[set_count] = it.src_y;
      set_dx[set_count] = it.dst_x;
      set_dy[set_count] = it.dst_y;
      set_count++;
      sum_sx += it.src_x;
      sum_sy += it.src_y;
      sum_dx += it.dst_x;
      sum_dy += it.dst_y;
    end else begin
      set_overflow = 1'b1;
    end
    if (!it.last) return;
    n = set_count;
    dot_sum = 0;
    cross_sum = 0;
    spread_sum = 0;
    for (int i = 0; i < set_count; i++) begin
      dot_sum += longint'(set_sx[i] * set_dx[i]) + longint'(set_sy[i] * set_dy[i]);
      cross_sum += longint'(set_sx[i] * set_dy[i]) - longint'(set_sy[i] * set_dx[i]);
      spread_sum += longint'(set_sx[i] * set_sx[i]) + longint'(set_sy[i] * set_sy[i]);
    end
    ssx = sum_sx;
    ssy = sum_sy;
    sdx = sum_dx;
    sdy = sum_dy;
    num_a = n * dot_sum - ssx * sdx - ssy * sdy;
    num_b = n * cross_sum - (ssx * sdy - ssy * sdx);
    den = n * spread_sum - ssx * ssx - ssy * ssy;
    fit = '0;
    fit.pair_count = n[CNT_W-1:0];
    if (set_overflow) begin
      fit.status = ST_OVF;
      overflow_sets++;
    end else if (n == 0 || den <= 0) begin
      fit.status = ST_DEGEN;
      degenerate_sets++;
    end else begin
      fit.status = ST_OK;
      fit.scale_cos = q16_ratio(num_a, den);
      fit.scale_sin = q16_ratio(num_b, den);
      ua = longint'(fit.scale_cos);
      ub = longint'(fit.scale_sin);
      fit.shift_x = rounded_shift(sdx * 65536 - (ua * ssx - ub * ssy), n * 65536);
      fit.shift_y = rounded_shift(sdy * 65536 - (ub * ssx + ua * ssy), n * 65536);
    end
    pending_fits.push_back(fit);
    set_count = 0;
    set_overflow = 1'b0;
    sum_sx = 0;
    sum_sy = 0;
    sum_dx = 0;
    sum_dy = 0;
  endtask

  task automatic send_pair(in_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    fit_model(it);
    items_sent++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d fits outstanding", cycles, pending_fits.size());
      $display("similarity_transform_fit_test: FAIL");
      $finish;
    end
  end

  // Result side: random stall, and every taken item is checked in order.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < out_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      fits_seen++;
      if (pending_fits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected fit result: %p", out_item);
      end else if (out_item !== pending_fits[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("fit %0d mismatch: expected %p, got %p", fits_seen, pending_fits[0], out_item);
        void'(pending_fits.pop_front());
      end else begin
        void'(pending_fits.pop_front());
      end
    end
  end

  typedef struct {
    in_item_t pair;
    int reps;
    bit typed;
    out_item_t want;
  } stim_row_t;

  function automatic stim_row_t row(int sx, int sy, int dx, int dy, bit last, int reps,
                                    bit typed, logic [1:0] st, int cnt,
                                    int a = 0, int b = 0);
    stim_row_t r;
    r.pair = '{src_x: sx, src_y: sy, dst_x: dx, dst_y: dy, last: last};
    r.reps = reps;
    r.typed = typed;
    r.want = '{scale_cos: a, scale_sin: b, shift_x: 0, shift_y: 0, status: st,
               pair_count: cnt};
    return r;
  endfunction

  function automatic int clamp_coord(longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return int'(v);
  endfunction

  stim_row_t directed[$];
  int set_len, kind, c, s, tx, ty, span;
  int sx, sy, fixed_sx, fixed_sy;
  in_item_t it;

  initial begin
    // Single pairs and repeated source points have no spread.
    directed.push_back(row(524287, 524287, 524287, 524287, 1, 1, 1, ST_DEGEN, 1));
    directed.push_back(row(-524288, -524288, -524288, -524288, 1, 1, 1, ST_DEGEN, 1));
    directed.push_back(row(-1000, 77, 5, -9, 1, 4, 1, ST_DEGEN, 4));
    // Identity and quarter turn over two pairs.
    directed.push_back(row(0, 0, 0, 0, 0, 1, 0, ST_OK, 0));
    directed.push_back(row(16, 0, 16, 0, 1, 1, 1, ST_OK, 2, 65536, 0));
    directed.push_back(row(0, 0, 0, 0, 0, 1, 0, ST_OK, 0));
    directed.push_back(row(16, 0, 0, 16, 1, 1, 1, ST_OK, 2, 0, 65536));
    // Coordinate extremes, coefficient and shift saturation.
    directed.push_back(row(-524288, -524288, 524287, 524287, 0, 1, 0, ST_OK, 0));
    directed.push_back(row(524287, 524287, -524288, -524288, 1, 1, 0, ST_OK, 0));
    directed.push_back(row(0, 0, 0, 0, 0, 1, 0, ST_OK, 0));
    directed.push_back(row(1, 0, 524287, 0, 1, 1, 0, ST_OK, 0));
    directed.push_back(row(0, 0, 0, 0, 0, 1, 0, ST_OK, 0));
    directed.push_back(row(1, 0, -524288, 0, 1, 1, 0, ST_OK, 0));
    directed.push_back(row(524287, 0, 524287, 0, 0, 1, 0, ST_OK, 0));
    directed.push_back(row(524286, 0, -524288, 0, 1, 1, 0, ST_OK, 0));
    // A full store and then two more pairs: the overflow status.
    directed.push_back(row(300, -200, 100, 50, 1, MAX_PAIRS + 2, 1, ST_OVF, MAX_PAIRS));
    // The set after an overflow starts clean.
    directed.push_back(row(-32, 48, 10, 20, 0, 1, 0, ST_OK, 0));
    directed.push_back(row(64, -16, -30, 7, 0, 1, 0, ST_OK, 0));
    directed.push_back(row(5, 5, 90, -60, 1, 1, 0, ST_OK, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      for (int k = 0; k < directed[i].reps; k++) begin
        it = directed[i].pair;
        it.last = directed[i].pair.last && (k == directed[i].reps - 1);
        send_pair(it);
      end
      if (directed[i].typed) begin
        void'(pending_fits.pop_back());
        pending_fits.push_back(directed[i].want);
      end
    end

    // Random sets: mostly noisy similarity maps, some raw full-range noise,
    // some degenerate sets and now and then a set that overruns the store.
    while (items_sent < RANDOM_ITEMS) begin
      in_idle_pct = (items_sent > 450 && items_sent < 650) ? 0 : 36;
      out_idle_pct = in_idle_pct;
      kind = $urandom_range(99);
      if (kind < 3) set_len = $urandom_range(MAX_PAIRS + 6, MAX_PAIRS - 2);
      else if (kind < 8) set_len = 1;
      else set_len = $urandom_range(12, 2);
      c = $urandom_range(1024) - 512;
      s = $urandom_range(1024) - 512;
      tx = $urandom_range(200000) - 100000;
      ty = $urandom_range(200000) - 100000;
      span = 1 << $urandom_range(17, 4);
      fixed_sx = $urandom_range(span) - span / 2;
      fixed_sy = $urandom_range(span) - span / 2;
      for (int k = 0; k < set_len; k++) begin
        if (kind >= 20 && kind < 30) begin
          it.src_x = $urandom;
          it.src_y = $urandom;
          it.dst_x = $urandom;
          it.dst_y = $urandom;
        end else begin
          sx = (kind >= 30 && kind < 36) ? fixed_sx : $urandom_range(span) - span / 2;
          sy = (kind >= 30 && kind < 36) ? fixed_sy : $urandom_range(span) - span / 2;
          it.src_x = sx;
          it.src_y = sy;
          it.dst_x = clamp_coord(((longint'(c) * sx - longint'(s) * sy) >>> 8) + tx
                                 + int'($urandom_range(8)) - 4);
          it.dst_y = clamp_coord(((longint'(s) * sx + longint'(c) * sy) >>> 8) + ty
                                 + int'($urandom_range(8)) - 4);
        end
        it.last = (k == set_len - 1);
        send_pair(it);
      end
    end
    in_valid <= 1'b0;

    while (pending_fits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d pairs sent in %0d cycles, %0d fits checked", items_sent, cycles, fits_seen);
    $display("%0d degenerate sets, %0d overrun sets, %0d mismatches",
             degenerate_sets, overflow_sets, mismatches);
    if (mismatches == 0 && pending_fits.size() == 0) begin
      $display("similarity_transform_fit_test: PASS");
    end else begin
      $display("similarity_transform_fit_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- similarity_transform_fit.f -----
hdl/sft_pkg.sv
hdl/sft_ram.sv
hdl/sft_div.sv
hdl/sft_fit.sv
hdl/similarity_transform_fit.sv
tb/similarity_transform_fit_test.sv
